@@ src/gtphc_pkg.sv @@
// Shared types, constants and tables for the go-to-point heading controller.
// No dependencies; used by gtphc_cordic and go_to_point_heading_controller.
`default_nettype none

package gtphc_pkg;

    // CORDIC depth and the pipeline latencies that follow from it
    localparam int CORDIC_STAGES = 16;
    localparam int NORM_STEPS    = 6;                       // shifts 32,16,8,4,2,1
    localparam int CORDIC_LAT    = CORDIC_STAGES + NORM_STEPS + 2;
    localparam int PIPE_LAST     = CORDIC_LAT + 3;          // output register index

    // Data widths
    localparam int VW = 34;     // goal offset, signed Q16.16
    localparam int CW = 44;     // CORDIC vector after normalization and gain
    localparam int MW = 41;     // normalized magnitude
    localparam int ZW = 34;     // CORDIC angle accumulator, Q2.30
    localparam int AW = 16;     // angle, Q3.13
    localparam int EW = 19;     // raw heading error before wrap

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [EW-1:0] PI_Q13      = 19'sd25736;
    localparam logic signed [EW-1:0] TWO_PI_Q13  = 19'sd51472;
    localparam logic signed [EW-1:0] THREE_PI_Q13 = 19'sd77208;
    localparam logic signed [EW-1:0] FOUR_PI_Q13 = 19'sd102944;

    // Register map (word index)
    localparam logic [2:0] REG_TARGET_X    = 3'd0;
    localparam logic [2:0] REG_TARGET_Y    = 3'd1;
    localparam logic [2:0] REG_ARRIVE_RAD  = 3'd2;
    localparam logic [2:0] REG_HEAD_GAIN   = 3'd3;
    localparam logic [2:0] REG_CRUISE      = 3'd4;
    localparam logic [2:0] REG_HEAD_TOL    = 3'd5;

    // Reset values
    localparam logic signed [31:0] RST_TARGET_X   = 32'sd196608;
    localparam logic signed [31:0] RST_TARGET_Y   = 32'sd131072;
    localparam logic [30:0]        RST_ARRIVE_RAD = 31'd19661;
    localparam logic [15:0]        RST_HEAD_GAIN  = 16'd256;
    localparam logic [17:0]        RST_CRUISE     = 18'd26214;
    localparam logic [14:0]        RST_HEAD_TOL   = 15'd2458;

    // Pose sample word
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } pose_t;

    // Drive command word
    typedef struct packed {
        logic signed [15:0] angular_rate;
        logic [17:0]        linear_speed;
        logic               reached;
    } cmd_t;

    // atan(2^-i) in Q2.30, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:  a = 34'sd843314857;
            1:  a = 34'sd497837830;
            2:  a = 34'sd263043837;
            3:  a = 34'sd133525159;
            4:  a = 34'sd67021687;
            5:  a = 34'sd33543515;
            6:  a = 34'sd16775851;
            7:  a = 34'sd8388437;
            8:  a = 34'sd4194283;
            9:  a = 34'sd2097149;
            10: a = 34'sd1048576;
            11: a = 34'sd524288;
            12: a = 34'sd262144;
            13: a = 34'sd131072;
            14: a = 34'sd65536;
            15: a = 34'sd32768;
            16: a = 34'sd16384;
            17: a = 34'sd8192;
            18: a = 34'sd4096;
            19: a = 34'sd2048;
            20: a = 34'sd1024;
            21: a = 34'sd512;
            22: a = 34'sd256;
            23: a = 34'sd128;
            24: a = 34'sd64;
            25: a = 34'sd32;
            26: a = 34'sd16;
            27: a = 34'sd8;
            28: a = 34'sd4;
            29: a = 34'sd2;
            30: a = 34'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

@@ src/go_to_point_heading_controller.sv @@
// Go-to-point heading controller top level: APB registers and the main pipeline.
// Depends on gtphc_pkg and gtphc_cordic (two instances, bearing and yaw).
//
//   port group   | dir | handshake              | word
//   pose         | in  | pose_valid/pose_ready  | pose_t: pos_x, pos_y, quat_z, quat_w
//   cmd          | out | cmd_valid/cmd_ready    | cmd_t: angular_rate, linear_speed, reached
//   apb          | in  | psel/penable, pready=1 | 32-bit registers at 4*index
//
// One pose word per cycle while the pipeline advances. The path runs through the goal
// offset, normalizer and CORDIC stages, then the error, gain and output registers.
// The whole pipeline advances together; it holds only while the output
// register holds a word that is not taken. Reset clears valid bits and
// loads the register defaults; no clearing pass.
`default_nettype none

module go_to_point_heading_controller
    import gtphc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pose_valid,
    output logic        pose_ready,
    input  pose_t       pose,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- configuration registers ----------------
    logic signed [31:0] target_x_reg, target_y_reg;
    logic [30:0]        arrive_rad_reg;
    logic [15:0]        head_gain_reg;
    logic [17:0]        cruise_reg;
    logic [14:0]        head_tol_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg   <= RST_TARGET_X;
            target_y_reg   <= RST_TARGET_Y;
            arrive_rad_reg <= RST_ARRIVE_RAD;
            head_gain_reg  <= RST_HEAD_GAIN;
            cruise_reg     <= RST_CRUISE;
            head_tol_reg   <= RST_HEAD_TOL;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_TARGET_X:   target_x_reg   <= pwdata;
                REG_TARGET_Y:   target_y_reg   <= pwdata;
                REG_ARRIVE_RAD: arrive_rad_reg <= pwdata[30:0];
                REG_HEAD_GAIN:  head_gain_reg  <= pwdata[15:0];
                REG_CRUISE:     cruise_reg     <= pwdata[17:0];
                REG_HEAD_TOL:   head_tol_reg   <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (paddr[4:2])
            REG_TARGET_X:   prdata = target_x_reg;
            REG_TARGET_Y:   prdata = target_y_reg;
            REG_ARRIVE_RAD: prdata = {1'b0, arrive_rad_reg};
            REG_HEAD_GAIN:  prdata = {16'd0, head_gain_reg};
            REG_CRUISE:     prdata = {14'd0, cruise_reg};
            REG_HEAD_TOL:   prdata = {17'd0, head_tol_reg};
            default:        prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic vld_reg [0:PIPE_LAST];

    assign en         = !vld_reg[PIPE_LAST] || cmd_ready;
    assign pose_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= PIPE_LAST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= pose_valid;
            for (int k = 1; k <= PIPE_LAST; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // ---------------- stage 0: goal offset ----------------
    logic signed [VW-1:0] dx_reg, dy_reg;
    logic signed [VW-1:0] qz_ext, qw_ext;
    logic signed [15:0]   qz_reg, qw_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= VW'(target_x_reg) - VW'(pose.pos_x);
            dy_reg <= VW'(target_y_reg) - VW'(pose.pos_y);
            qz_reg <= pose.quat_z;
            qw_reg <= pose.quat_w;
        end
    end

    assign qz_ext = VW'(qz_reg);
    assign qw_ext = VW'(qw_reg);

    // ---------------- stage 1: squares ----------------
    logic signed [VW-1:0] adx, ady;
    logic [61:0]          dx2_reg, dy2_reg, r2_reg;
    logic                 near_reg;

    assign adx = (dx_reg < 0) ? -dx_reg : dx_reg;
    assign ady = (dy_reg < 0) ? -dy_reg : dy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            near_reg <= (adx[VW-1:31] == '0) && (ady[VW-1:31] == '0);
            dx2_reg  <= adx[30:0] * adx[30:0];
            dy2_reg  <= ady[30:0] * ady[30:0];
            r2_reg   <= arrive_rad_reg * arrive_rad_reg;
        end
    end

    // ---------------- stage 2 onward: arrival flag delay line ----------------
    logic        rch_reg [2:PIPE_LAST-1];
    logic [62:0] d2_sum;

    assign d2_sum = {1'b0, dx2_reg} + {1'b0, dy2_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rch_reg[2] <= near_reg && (d2_sum <= {1'b0, r2_reg});
            for (int k = 3; k < PIPE_LAST; k++)
            begin
                rch_reg[k] <= rch_reg[k-1];
            end
        end
    end

    // ---------------- bearing and half yaw ----------------
    logic signed [AW-1:0] bearing, yaw_half;

    gtphc_cordic u_bearing (
        .clk   (clk),
        .en    (en),
        .vec_x (dx_reg),
        .vec_y (dy_reg),
        .angle (bearing)
    );

    gtphc_cordic u_yaw (
        .clk   (clk),
        .en    (en),
        .vec_x (qw_ext),
        .vec_y (qz_ext),
        .angle (yaw_half)
    );

    // ---------------- error and wrap ----------------
    logic signed [EW-1:0] err_raw, err_wrap;
    logic signed [AW-1:0] err_reg;

    assign err_raw = EW'(bearing) - (EW'(yaw_half) <<< 1);

    always_comb
    begin
        if (err_raw > THREE_PI_Q13)
            err_wrap = err_raw - FOUR_PI_Q13;
        else if (err_raw > PI_Q13)
            err_wrap = err_raw - TWO_PI_Q13;
        else if (err_raw < -THREE_PI_Q13)
            err_wrap = err_raw + FOUR_PI_Q13;
        else if (err_raw < -PI_Q13)
            err_wrap = err_raw + TWO_PI_Q13;
        else
            err_wrap = err_raw;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err_reg <= err_wrap[AW-1:0];
        end
    end

    // ---------------- gain product and tolerance ----------------
    logic signed [32:0]   prod_reg;
    logic                 aligned_reg;
    logic signed [AW-1:0] err_abs;

    assign err_abs = (err_reg < 0) ? -err_reg : err_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= $signed({1'b0, head_gain_reg}) * err_reg;
            aligned_reg <= err_abs < $signed({1'b0, head_tol_reg});
        end
    end

    // ---------------- round, saturate, output register ----------------
    logic signed [32:0] rnd_full;
    logic signed [24:0] rnd;
    logic signed [15:0] ang_sat;
    cmd_t               cmd_reg;
    cmd_t               cmd_next;

    assign rnd_full = prod_reg + 33'sd128;
    assign rnd      = rnd_full[32:8];

    always_comb
    begin
        if (rnd > 25'sd32767)
            ang_sat = 16'sh7FFF;
        else if (rnd < -25'sd32768)
            ang_sat = 16'sh8000;
        else
            ang_sat = rnd[15:0];

        if (rch_reg[PIPE_LAST-1])
        begin
            cmd_next.angular_rate = '0;
            cmd_next.linear_speed = '0;
            cmd_next.reached      = 1'b1;
        end
        else
        begin
            cmd_next.angular_rate = ang_sat;
            cmd_next.linear_speed = aligned_reg ? cruise_reg : '0;
            cmd_next.reached      = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd       = cmd_reg;
    assign cmd_valid = vld_reg[PIPE_LAST];

    // ---------------- assertions ----------------
    a_reached_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd.reached |-> cmd.angular_rate == 0 && cmd.linear_speed == 0)
        else $error("reached word carries nonzero speed");

    a_speed_choice: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> cmd.linear_speed == 0 || cmd.linear_speed == cruise_reg)
        else $error("linear speed neither zero nor cruise");

    a_err_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[CORDIC_LAT+1] |-> err_reg <= 16'sd25736 && err_reg >= -16'sd25736)
        else $error("heading error outside [-pi, pi]");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_valid |-> pose_ready)
        else $error("input stalled with empty output register");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg[0]) && $stable(err_reg))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire

@@ src/gtphc_cordic.sv @@
// Pipelined vectoring CORDIC computing atan2(y, x) in Q3.13.
// Depends on gtphc_pkg; the pipeline advances when en is high.
`default_nettype none

module gtphc_cordic
    import gtphc_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [VW-1:0] vec_x,
    input  logic signed [VW-1:0] vec_y,
    output logic signed [AW-1:0] angle
);

    localparam int LAST = NORM_STEPS + CORDIC_STAGES;

    logic signed [CW-1:0] x_reg [0:LAST];
    logic signed [CW-1:0] y_reg [0:LAST];
    logic signed [ZW-1:0] z_reg [0:LAST];
    logic                 zf_reg [0:LAST];
    logic [MW-1:0]        m_reg [0:NORM_STEPS-1];
    logic signed [AW-1:0] angle_reg;

    logic signed [CW-1:0] ex, ey, rx, ry, ax, ay;
    logic signed [ZW-1:0] rz;
    logic signed [ZW-1:0] zsum;

    // Pre-rotation into the right half plane
    always_comb
    begin
        ex = {{(CW-VW){vec_x[VW-1]}}, vec_x};
        ey = {{(CW-VW){vec_y[VW-1]}}, vec_y};
        rx = ex;
        ry = ey;
        rz = '0;
        if (ex < 0)
        begin
            if (ey >= 0)
            begin
                rx = ey;
                ry = -ex;
                rz = HALF_PI_Q30;
            end
            else
            begin
                rx = -ey;
                ry = ex;
                rz = -HALF_PI_Q30;
            end
        end
        ax = (rx < 0) ? -rx : rx;
        ay = (ry < 0) ? -ry : ry;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]  <= rx;
            y_reg[0]  <= ry;
            z_reg[0]  <= rz;
            zf_reg[0] <= (vec_x == '0) && (vec_y == '0);
            m_reg[0]  <= (ax > ay) ? ax[MW-1:0] : ay[MW-1:0];
        end
    end

    // Normalization: binary leading-zero shift until magnitude reaches 2^40
    for (genvar j = 0; j < NORM_STEPS; j++)
    begin : g_norm
        localparam int K = 32 >> j;
        logic do_shift;
        assign do_shift = (m_reg[j][MW-1 -: K] == '0);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[j+1]  <= do_shift ? (x_reg[j] <<< K) : x_reg[j];
                y_reg[j+1]  <= do_shift ? (y_reg[j] <<< K) : y_reg[j];
                z_reg[j+1]  <= z_reg[j];
                zf_reg[j+1] <= zf_reg[j];
            end
        end

        if (j < NORM_STEPS - 1)
        begin : g_mag
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    m_reg[j+1] <= do_shift ? (m_reg[j] << K) : m_reg[j];
                end
            end
        end
    end

    // Micro-rotations, one per stage
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_iter
        localparam int P = NORM_STEPS + i;
        localparam logic signed [ZW-1:0] ATN = atan_q30(i);
        logic signed [CW-1:0] xs, ys;
        assign xs = x_reg[P] >>> i;
        assign ys = y_reg[P] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[P] > 0)
                begin
                    x_reg[P+1] <= x_reg[P] + ys;
                    y_reg[P+1] <= y_reg[P] - xs;
                    z_reg[P+1] <= z_reg[P] + ATN;
                end
                else
                begin
                    x_reg[P+1] <= x_reg[P] - ys;
                    y_reg[P+1] <= y_reg[P] + xs;
                    z_reg[P+1] <= z_reg[P] - ATN;
                end
                zf_reg[P+1] <= zf_reg[P];
            end
        end
    end

    // Round Q2.30 to Q3.13; zero vector gives zero
    assign zsum = z_reg[LAST] + ZW'(65536);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= zf_reg[LAST] ? '0 : zsum[AW+16:17];
        end
    end

    assign angle = angle_reg;

endmodule

`default_nettype wire
